### hw/rtl/fpa_pkg.sv
// Shared types and constants of the fixed-partition first-fit allocator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package fpa_pkg;

  // Field widths of the request, result and configuration channels
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PIDX_W   = 2;
  localparam int unsigned PCOUNT_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Defaults of the top-level parameters
  localparam int unsigned NUM_PARTITIONS_DEF = 4;
  localparam int unsigned SIZE_BITS_DEF      = 24;

  // Reset value of the partition count register
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(4);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CAPACITY  = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_CAP = 3'd0,
    REG_PART_CNT  = 3'd1,
    REG_SIZE_0    = 3'd2,
    REG_SIZE_1    = 3'd3,
    REG_SIZE_2    = 3'd4,
    REG_SIZE_3    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    req_kind_e         req_type;
    logic [ID_W-1:0]   owner_id;
    logic [SIZE_W-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PIDX_W-1:0] partition_index;
    logic [SIZE_W-1:0] moved_bytes;
    logic [SIZE_W-1:0] used_total;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/fpa_if.sv
// Channel interfaces of the allocator: request, result and configuration write.
// Depends on fpa_pkg for the payload types and widths.
`default_nettype none

interface fpa_req_if;
  logic          valid;
  logic          ready;
  fpa_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpa_rsp_if;
  logic          valid;
  logic          ready;
  fpa_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fpa_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [fpa_pkg::SIZE_W-1:0]       wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/fixed_partition_first_fit_allocator.sv
// Top level of the fixed-partition first-fit allocator: request stage,
// parallel partition match with priority pick, result register.
// Depends on fpa_pkg and the channel interfaces in fpa_if.sv.
`default_nettype none

//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------
//  req_i    | in  | valid/ready  | req_type, owner_id, request_bytes
//  rsp_o    | out | valid/ready  | status, partition_index, moved_bytes,
//           |     |              | used_total
//  cfg_i    | in  | valid/ready  | reg_index, wdata (always ready)
//
//  A request is taken into the request register, and in the next cycle all
//  partitions are compared in parallel and the lowest match is picked; the
//  partition table and used total update as the result enters the result
//  register. One request per cycle sustained while the result register drains.
//  A stalled result holds the request register; req ready then drops.
//  Reset frees all partitions and clears the used total; no clearing pass.

module fixed_partition_first_fit_allocator #(
  parameter int unsigned NUM_PARTITIONS = fpa_pkg::NUM_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = fpa_pkg::SIZE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpa_req_if.sink     req_i,
  fpa_rsp_if.source   rsp_o,
  fpa_cfg_if.sink     cfg_i
);
  import fpa_pkg::*;

  // Stored size width: sizes never exceed the 24-bit fields
  localparam int unsigned SW    = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam int unsigned IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  // Configuration registers
  logic [SW-1:0]       cap_q;
  logic [PCOUNT_W-1:0] pcount_q;
  logic [SW-1:0]       size_q [NUM_PARTITIONS];

  // Partition table and used total
  logic [NUM_PARTITIONS-1:0] busy_q, busy_d;
  logic [ID_W-1:0]           owner_q [NUM_PARTITIONS];
  logic [SW-1:0]             amount_q [NUM_PARTITIONS];
  logic [SW-1:0]             used_q, used_d;

  // Request stage and result register
  logic     s1_valid_q;
  req_t     s1_q;
  logic     rsp_valid_q;
  rsp_t     rsp_q, rsp_d;
  logic     s1_adv;
  logic     req_fire;

  // Match logic
  logic [SW-1:0]             req_bytes;
  logic [SW:0]               sum_bytes;
  logic                      cap_fail;
  logic [NUM_PARTITIONS-1:0] exists;
  logic [NUM_PARTITIONS-1:0] alloc_hit, free_hit, hit, grant;
  logic [IDX_W-1:0]          pick;
  logic [SW-1:0]             rel_amount;
  logic                      do_alloc;

  assign cfg_i.ready = 1'b1;

  // Advance the request stage whenever the result register is free or drains
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;

  assign req_bytes = s1_q.request_bytes[SW-1:0];
  assign sum_bytes = {1'b0, used_q} + {1'b0, req_bytes};
  assign cap_fail  = sum_bytes > {1'b0, cap_q};

  // Compare every partition in parallel
  always_comb begin
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      exists[i]    = PCOUNT_W'(i) < pcount_q;
      alloc_hit[i] = exists[i] && !busy_q[i] && (size_q[i] >= req_bytes);
      free_hit[i]  = exists[i] && busy_q[i] && (owner_q[i] == s1_q.owner_id);
    end
  end

  // Keep the lowest matching partition
  assign hit   = (s1_q.req_type == REQ_FREE) ? free_hit : alloc_hit;
  assign grant = hit & (~hit + NUM_PARTITIONS'(1));

  always_comb begin
    pick = '0;
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      if (grant[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  assign rel_amount = amount_q[pick];
  assign do_alloc   = (s1_q.req_type == REQ_ALLOC) && !cap_fail && (hit != '0);

  // Build the result and the next table state
  always_comb begin
    busy_d = busy_q;
    used_d = used_q;
    rsp_d  = '{status: ST_OK, partition_index: '0, moved_bytes: '0,
               used_total: '0};
    if (s1_q.req_type == REQ_ALLOC) begin
      if (cap_fail) begin
        rsp_d.status = ST_CAPACITY;
      end else if (hit == '0) begin
        rsp_d.status = ST_NO_FIT;
      end else begin
        busy_d[pick]          = 1'b1;
        used_d                = sum_bytes[SW-1:0];
        rsp_d.partition_index = PIDX_W'(pick);
        rsp_d.moved_bytes     = SIZE_W'(req_bytes);
      end
    end else begin
      if (hit == '0) begin
        rsp_d.status = ST_NOT_FOUND;
      end else begin
        busy_d[pick]          = 1'b0;
        used_d                = (used_q >= rel_amount) ? (used_q - rel_amount) : '0;
        rsp_d.partition_index = PIDX_W'(pick);
        rsp_d.moved_bytes     = SIZE_W'(rel_amount);
      end
    end
    rsp_d.used_total = SIZE_W'(used_d);
  end

  // Hold configuration; writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= '0;
      pcount_q <= PCOUNT_RESET;
      for (int i = 0; i < NUM_PARTITIONS; i++) begin
        size_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_TOTAL_CAP: cap_q    <= cfg_i.wdata[SW-1:0];
        REG_PART_CNT:  pcount_q <= cfg_i.wdata[PCOUNT_W-1:0];
        REG_SIZE_0, REG_SIZE_1, REG_SIZE_2, REG_SIZE_3: begin
          for (int i = 0; i < NUM_PARTITIONS; i++) begin
            if (cfg_i.reg_index == CFG_IDX_W'(int'(REG_SIZE_0) + i)) begin
              size_q[i] <= cfg_i.wdata[SW-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Advance busy flags, used total and the valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      used_q      <= '0;
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        busy_q <= busy_d;
        used_q <= used_d;
      end
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request, result and the owner/amount records
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_q <= req_i.data;
    end
    if (s1_adv) begin
      rsp_q <= rsp_d;
    end
    if (s1_adv && do_alloc) begin
      owner_q[pick]  <= s1_q.owner_id;
      amount_q[pick] <= req_bytes;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Only one partition may be picked per request
  a_grant_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(grant))
    else $error("more than one partition granted");

  // Table and used total change only when a request completes
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(busy_q) && $stable(used_q)))
    else $error("allocator state changed without a request");

  // At most one partition changes its busy flag per request
  a_busy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ($countones(busy_q ^ $past(busy_q)) <= 1))
    else $error("more than one busy flag changed");

  // Error results carry neither a partition nor bytes
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status != ST_OK)) |->
      ((rsp_q.partition_index == '0) && (rsp_q.moved_bytes == '0)))
    else $error("error result with nonzero partition or bytes");

  // Request input stalls only behind a full, stalled pipeline
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && rsp_valid_q && !rsp_o.ready))
    else $error("request input stalled without backpressure");

endmodule

`default_nettype wire

### verif/fpa_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the allocator testbench: mirrors the partition table and checks every result.
// Depends on fpa_pkg and the channel interfaces in fpa_if.sv.
module fpa_checker
  import fpa_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpa_req_if          req_i,
  fpa_rsp_if          rsp_i,
  fpa_cfg_if          cfg_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned SLOTS = NUM_PARTITIONS_DEF;

  // Mirrored configuration
  logic [SIZE_W-1:0]   cap_limit;
  logic [PCOUNT_W-1:0] part_count;
  logic [SIZE_W-1:0]   part_size  [SLOTS];

  // Mirrored partition table and used total
  logic                slot_taken [SLOTS];
  logic [ID_W-1:0]     slot_id    [SLOTS];
  logic [SIZE_W-1:0]   slot_bytes [SLOTS];
  logic [SIZE_W-1:0]   bytes_in_use;

  rsp_t                awaited_rsp_q [$];
  rsp_t                oldest_rsp;
  int unsigned         mismatches = 0;

  // Apply one request to the mirrored table and return the result it must produce
  function automatic rsp_t serve_request(req_t r);
    rsp_t        res;
    int unsigned live;
    bit          hit;
    res = '0;
    res.status = ST_OK;
    live = (part_count > SLOTS) ? SLOTS : part_count;
    hit = 1'b0;
    if (r.req_type == REQ_ALLOC) begin
      if ({1'b0, bytes_in_use} + {1'b0, r.request_bytes} > {1'b0, cap_limit}) begin
        res.status = ST_CAPACITY;
      end else begin
        // first fit: lowest existing free partition that is large enough
        for (int i = 0; i < live; i++) begin
          if (!hit && !slot_taken[i] && part_size[i] >= r.request_bytes) begin
            hit = 1'b1;
            res.partition_index = PIDX_W'(i);
          end
        end
        if (!hit) begin
          res.status = ST_NO_FIT;
          res.partition_index = '0;
        end else begin
          slot_taken[res.partition_index] = 1'b1;
          slot_id[res.partition_index]    = r.owner_id;
          slot_bytes[res.partition_index] = r.request_bytes;
          bytes_in_use = bytes_in_use + r.request_bytes;
          res.moved_bytes = r.request_bytes;
        end
      end
    end else begin
      // release the lowest existing busy partition of this owner
      for (int i = 0; i < live; i++) begin
        if (!hit && slot_taken[i] && slot_id[i] == r.owner_id) begin
          hit = 1'b1;
          res.partition_index = PIDX_W'(i);
        end
      end
      if (!hit) begin
        res.status = ST_NOT_FOUND;
        res.partition_index = '0;
      end else begin
        res.moved_bytes = slot_bytes[res.partition_index];
        slot_taken[res.partition_index] = 1'b0;
        bytes_in_use = (bytes_in_use >= res.moved_bytes) ?
                       bytes_in_use - res.moved_bytes : '0;
      end
    end
    res.used_total = bytes_in_use;
    return res;
  endfunction

  task automatic check_field(string name, logic [SIZE_W-1:0] expv, logic [SIZE_W-1:0] actv);
    if (expv !== actv) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
    end
  endtask

  // Track register writes, predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit  = '0;
      part_count = PCOUNT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        part_size[i]  = '0;
        slot_taken[i] = 1'b0;
        slot_id[i]    = '0;
        slot_bytes[i] = '0;
      end
      bytes_in_use = '0;
      awaited_rsp_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= mismatches;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          REG_TOTAL_CAP: cap_limit = cfg_i.wdata;
          REG_PART_CNT:  part_count = cfg_i.wdata[PCOUNT_W-1:0];
          REG_SIZE_0:    part_size[0] = cfg_i.wdata;
          REG_SIZE_1:    part_size[1] = cfg_i.wdata;
          REG_SIZE_2:    part_size[2] = cfg_i.wdata;
          REG_SIZE_3:    part_size[3] = cfg_i.wdata;
          default: ;
        endcase
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_i.data);
        end else begin
          oldest_rsp = awaited_rsp_q.pop_front();
          check_field("status", SIZE_W'(oldest_rsp.status), SIZE_W'(rsp_i.data.status));
          check_field("partition_index", SIZE_W'(oldest_rsp.partition_index),
                      SIZE_W'(rsp_i.data.partition_index));
          check_field("moved_bytes", oldest_rsp.moved_bytes, rsp_i.data.moved_bytes);
          check_field("used_total", oldest_rsp.used_total, rsp_i.data.used_total);
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_rsp_q.insert(awaited_rsp_q.size(), serve_request(req_i.data));
      end
      pending_o  <= awaited_rsp_q.size();
      fail_cnt_o <= mismatches;
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
// Depends on fpa_pkg, fpa_if.sv, the allocator and fpa_checker.
module tb;
  import fpa_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_REQS  = 235;
  localparam int unsigned HOLD_AFTER  = 600;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam longint     LIMIT_NS    = 8_000_000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BEAT
  } rx_mode_e;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned accepted_cnt = 0;
  logic [ID_W-1:0] id_pool [8];

  fpa_req_if req_ch ();
  fpa_rsp_if rsp_ch ();
  fpa_cfg_if cfg_ch ();

  fixed_partition_first_fit_allocator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  fpa_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .rsp_i      (rsp_ch),
    .cfg_i      (cfg_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request and hold it until taken; valid stays high afterward
  task automatic send_request(req_kind_e kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] nbytes);
    req_t r;
    r.req_type      = kind;
    r.owner_id      = id;
    r.request_bytes = nbytes;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    accepted_cnt++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [SIZE_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Drain all outstanding requests, then rewrite every register
  task automatic configure(logic [SIZE_W-1:0] cap, logic [SIZE_W-1:0] cnt_word,
                           logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                           logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    @(posedge clk);
    write_reg(REG_TOTAL_CAP, cap);
    write_reg(REG_PART_CNT, cnt_word);
    write_reg(REG_SIZE_0, s0);
    write_reg(REG_SIZE_1, s1);
    write_reg(REG_SIZE_2, s2);
    write_reg(REG_SIZE_3, s3);
    cfg_ch.valid <= 1'b0;
  endtask

  // Request stimulus: directed cases, then random phases under varied settings
  initial begin
    bit              wide;
    int unsigned     burst_left;
    int unsigned     roll;
    req_kind_e       kind;
    logic [ID_W-1:0] id;
    logic [SIZE_W-1:0] nbytes;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] cnt_word;
    logic [SIZE_W-1:0] sz [4];

    req_ch.valid     <= 1'b0;
    req_ch.data      <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_TOTAL_CAP;
    cfg_ch.wdata     <= '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < 8; k++) id_pool[k] = ID_W'($urandom());
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero capacity, all sizes zero
    send_request(REQ_ALLOC, 16'h0000, 24'd0);
    send_request(REQ_ALLOC, 16'h0001, 24'd1);
    send_request(REQ_FREE,  16'h0000, 24'd0);
    send_request(REQ_FREE,  16'h0000, 24'd0);

    // full capacity, mixed sizes: first fit, full-size request, no fit when all busy
    configure(24'hFFFFFF, 24'd4, 24'd10, 24'hFFFFFF, 24'd5, 24'd100);
    send_request(REQ_ALLOC, 16'hFFFF, 24'hFFFFFF);
    send_request(REQ_ALLOC, 16'h0001, 24'd1);
    send_request(REQ_FREE,  16'hFFFF, 24'hFFFFFF);
    send_request(REQ_ALLOC, 16'h0001, 24'd20);
    send_request(REQ_ALLOC, 16'h0002, 24'd5);
    send_request(REQ_ALLOC, 16'h0002, 24'd5);
    send_request(REQ_ALLOC, 16'h0003, 24'd200);
    send_request(REQ_ALLOC, 16'h0003, 24'd50);
    send_request(REQ_ALLOC, 16'h0004, 24'd0);
    send_request(REQ_FREE,  16'h0002, 24'd0);
    send_request(REQ_FREE,  16'h0007, 24'd0);

    // shrink the partition count: dropped busy partitions are hidden
    configure(24'hFFFFFF, 24'd2, 24'd10, 24'hFFFFFF, 24'd5, 24'd100);
    send_request(REQ_FREE,  16'h0003, 24'd0);
    send_request(REQ_ALLOC, 16'h0005, 24'd10);

    // no partition at all
    configure(24'hFFFFFF, 24'd0, 24'd10, 24'hFFFFFF, 24'd5, 24'd100);
    send_request(REQ_ALLOC, 16'h0006, 24'd0);
    send_request(REQ_FREE,  16'h0001, 24'd0);

    // count above the partition number: all exist again
    configure(24'hFFFFFF, 24'd7, 24'd10, 24'hFFFFFF, 24'd5, 24'd100);
    send_request(REQ_FREE,  16'h0003, 24'd0);

    // capacity below the used total: allocates refused, frees still work
    configure(24'd1, 24'd4, 24'd10, 24'hFFFFFF, 24'd5, 24'd100);
    send_request(REQ_ALLOC, 16'h0006, 24'd0);
    send_request(REQ_FREE,  16'h0001, 24'd0);
    send_request(REQ_FREE,  16'h0002, 24'd0);
    send_request(REQ_FREE,  16'h0005, 24'd0);
    send_request(REQ_ALLOC, 16'h0006, 24'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wide = (ph % 2) == 1;
      cnt_word = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(1, 4));
      // junk above the count field now and then
      if ($urandom_range(0, 3) == 0) cnt_word = cnt_word | SIZE_W'($urandom() & 24'hFFFFF8);
      for (int k = 0; k < 4; k++) begin
        if (wide) begin
          case ($urandom_range(0, 3))
            0:       sz[k] = '1;
            1:       sz[k] = SIZE_W'($urandom() >> $urandom_range(8, 31));
            default: sz[k] = SIZE_W'($urandom());
          endcase
        end else begin
          sz[k] = SIZE_W'($urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 3) == 0) cap = '1;
      else if (wide) cap = SIZE_W'($urandom());
      else cap = SIZE_W'($urandom_range(64, 900));
      configure(cap, cnt_word, sz[0], sz[1], sz[2], sz[3]);

      for (int n = 0; n < PHASE_REQS; n++) begin
        // sender bursts with random gaps between them
        if (burst_left == 0) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          kind   = req_kind_e'($urandom_range(0, 1));
          id     = ID_W'($urandom());
          nbytes = SIZE_W'($urandom());
        end else begin
          kind = (roll < 55) ? REQ_ALLOC : REQ_FREE;
          id   = id_pool[3'($urandom_range(0, 7))];
          if (wide) nbytes = SIZE_W'($urandom_range(0, sz[2'($urandom_range(0, 3))]));
          else nbytes = SIZE_W'($urandom_range(0, 280));
          if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, 1) ? '1 : '0;
        end
        send_request(kind, id, nbytes);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result sink: stall pattern per segment, plus one long hold-off mid-run
  initial begin
    rx_mode_e    mode;
    int unsigned seg_len;
    int unsigned beat;
    bit          held;
    rsp_ch.ready <= 1'b0;
    beat = 0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && accepted_cnt >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        seg_len = $urandom_range(8, 120);
        repeat (seg_len) begin
          case (mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default:   rsp_ch.ready <= beat[2];
          endcase
          beat++;
          @(posedge clk);
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
